// ===== design/sccq_pkg.sv =====
// ----------------------------------------------------------------------------
// sccq_pkg
// Shared types and constants for the signal change to command queue.
// ----------------------------------------------------------------------------
package sccq_pkg;

   localparam int QueueDepth = 64;
   localparam int PtrWidth   = $clog2(QueueDepth);

   localparam logic [10:0] MatchIdReset = 11'h2CF;

   localparam logic [4:0] EffAmbient = 5'd0;
   localparam logic [4:0] EffTheme0  = 5'd1;
   localparam logic [4:0] EffNap0    = 5'd7;
   localparam logic [4:0] EffStart   = 5'd12;
   localparam logic [4:0] EffTemp    = 5'd15;
   localparam logic [4:0] EffVoice   = 5'd16;
   localparam logic [4:0] EffDoor    = 5'd17;
   localparam logic [4:0] EffRear    = 5'd18;
   localparam logic [4:0] EffTweeter = 5'd19;
   localparam logic [4:0] EffVideo   = 5'd20;

   localparam logic ActExamine = 1'b0;
   localparam logic ActPop     = 1'b1;

   localparam logic KindDeactivate = 1'b0;
   localparam logic KindActivate   = 1'b1;

   typedef struct packed {
      logic        action;
      logic [10:0] frame_id;
      logic [31:0] timestamp;
      logic [7:0]  power_state;
      logic [7:0]  theme_code;
      logic [7:0]  nap_code;
      logic [23:0] motion_welcome_drive;
      logic [7:0]  voice_code;
      logic [11:0] corner_flags;
      logic [7:0]  tweeter_code;
      logic        video_active;
   } req_type;

   typedef struct packed {
      logic        found;
      logic        command_kind;
      logic [4:0]  effect_id;
      logic [31:0] command_time;
   } rsp_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  effect;
      logic [31:0] time_ms;
   } entry_type;

endpackage

// ===== design/sccq_ring.sv =====
// ----------------------------------------------------------------------------
// sccq_ring
// Command ring: one write at the tail and one registered read at the head.
// ----------------------------------------------------------------------------
module sccq_ring (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  sccq_pkg::entry_type push_data,
   input  logic                pop_en,
   output sccq_pkg::entry_type rd_data,
   output logic                empty
);
   import sccq_pkg::*;

   entry_type             mem [QueueDepth];
   entry_type             rd_data_ff;
   logic [PtrWidth-1:0]   head_ff, head_in;
   logic [PtrWidth-1:0]   tail_ff, tail_in;
   logic [PtrWidth-1:0]   tail_next;
   logic [PtrWidth-1:0]   head_next;
   logic                  full;

   assign tail_next = (tail_ff == PtrWidth'(QueueDepth - 1)) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == PtrWidth'(QueueDepth - 1)) ? '0 : head_ff + 1'b1;
   assign full      = (tail_next == head_ff);
   assign empty     = (tail_ff == head_ff);
   assign rd_data   = rd_data_ff;

   always_comb begin
      tail_in = tail_ff;
      head_in = head_ff;
      if (push_en && !full) begin
         tail_in = tail_next;
      end
      if (pop_en && !empty) begin
         head_in = head_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && !full) begin
         mem[tail_ff] <= push_data;
      end
      rd_data_ff <= mem[head_ff];
   end

endmodule

// ===== design/signal_change_to_command_queue_top.sv =====
// ----------------------------------------------------------------------------
// signal_change_to_command_queue_top
// Turns changes of vehicle signals into queued effect commands.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An examine request
// whose frame id equals the csr match id runs fourteen check steps, one per
// cycle, through one shared compare unit; each step may write one command
// into the 63-entry ring, and a power state of zero ends the run after the
// power step. A frame with another id is dropped at once and leaves busy low.
// A pop request reads the ring head through its registered read port: busy
// stays high through the read state and then the output state, in which the
// response strobe rises and lasts one cycle. The receiver cannot stall, so
// each response is taken in the cycle it is shown. An empty ring gives a
// response with found low and all fields zero. Reset clears the stored
// signal values and ring pointers (not the ring memory) and sets the match
// id to 0x2CF. The user must write the csr only while idle; it is unchecked.
// ----------------------------------------------------------------------------
module signal_change_to_command_queue_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sccq_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output sccq_pkg::rsp_type rsp_payload,
   input  logic              csr_write_en,
   input  logic [10:0]       csr_write_data
);
   import sccq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXAM,
      ST_POP_READ,
      ST_POP_OUT
   } state_type;

   typedef enum logic [3:0] {
      SP_POWER,
      SP_THEME_OLD,
      SP_THEME_NEW,
      SP_NAP_OLD,
      SP_NAP_NEW,
      SP_START,
      SP_WELCOME,
      SP_DRIVING,
      SP_CLIMATE,
      SP_VOICE,
      SP_DOOR,
      SP_REAR,
      SP_TWEETER,
      SP_VIDEO
   } step_type;

   state_type   state_ff;
   step_type    step_ff;
   req_type     req_ff;
   logic [10:0] match_id_ff;
   logic [7:0]  last_power_ff;
   logic [7:0]  last_theme_ff;
   logic [7:0]  last_nap_ff;
   logic [23:0] last_mwd_ff;
   logic [7:0]  last_voice_ff;
   logic [11:0] last_corner_ff;
   logic [7:0]  last_tweeter_ff;
   logic        last_video_ff;

   logic        accept;
   logic        want;
   logic        kind;
   logic [4:0]  effect;
   logic [7:0]  now_op;
   logic [7:0]  old_op;
   logic        op_changed;
   entry_type   push_data;
   entry_type   rd_data;
   logic        empty;
   logic        pop_en;

   function automatic logic voice_engaged(input logic [7:0] v);
      voice_engaged = (v == 8'd2) || (v == 8'd4) || (v == 8'd7);
   endfunction

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // shared compare unit with per-step operand select
   always_comb begin
      now_op = '0;
      old_op = '0;
      unique case (step_ff)
         SP_POWER: begin
            now_op = req_ff.power_state;
            old_op = last_power_ff;
         end
         SP_THEME_OLD, SP_THEME_NEW: begin
            now_op = req_ff.theme_code;
            old_op = last_theme_ff;
         end
         SP_NAP_OLD, SP_NAP_NEW: begin
            now_op = req_ff.nap_code;
            old_op = last_nap_ff;
         end
         SP_START: begin
            now_op = req_ff.motion_welcome_drive[7:0];
            old_op = last_mwd_ff[7:0];
         end
         SP_WELCOME: begin
            now_op = req_ff.motion_welcome_drive[15:8];
            old_op = last_mwd_ff[15:8];
         end
         SP_DRIVING: begin
            now_op = req_ff.motion_welcome_drive[23:16];
            old_op = last_mwd_ff[23:16];
         end
         SP_CLIMATE: begin
            now_op = {7'd0, |req_ff.corner_flags[3:0]};
            old_op = {7'd0, |last_corner_ff[3:0]};
         end
         SP_VOICE: begin
            now_op = {7'd0, voice_engaged(req_ff.voice_code)};
            old_op = {7'd0, voice_engaged(last_voice_ff)};
         end
         SP_DOOR: begin
            now_op = {7'd0, |req_ff.corner_flags[7:4]};
            old_op = {7'd0, |last_corner_ff[7:4]};
         end
         SP_REAR: begin
            now_op = {7'd0, |req_ff.corner_flags[11:8]};
            old_op = {7'd0, |last_corner_ff[11:8]};
         end
         SP_TWEETER: begin
            now_op = req_ff.tweeter_code;
            old_op = last_tweeter_ff;
         end
         SP_VIDEO: begin
            now_op = {7'd0, req_ff.video_active};
            old_op = {7'd0, last_video_ff};
         end
         default: begin
            now_op = '0;
            old_op = '0;
         end
      endcase
   end

   assign op_changed = (now_op != old_op);

   always_comb begin
      want   = op_changed;
      kind   = (now_op != 8'd0) ? KindActivate : KindDeactivate;
      effect = EffAmbient;
      unique case (step_ff)
         SP_POWER: begin
            effect = EffAmbient;
         end
         SP_THEME_OLD: begin
            want   = op_changed && (old_op <= 8'd6);
            kind   = KindDeactivate;
            effect = EffTheme0 + old_op[4:0];
         end
         SP_THEME_NEW: begin
            want   = op_changed && (now_op <= 8'd6);
            kind   = KindActivate;
            effect = EffTheme0 + now_op[4:0];
         end
         SP_NAP_OLD: begin
            want   = op_changed && (old_op >= 8'd1) && (old_op <= 8'd4);
            kind   = KindDeactivate;
            effect = EffNap0 + old_op[4:0];
         end
         SP_NAP_NEW: begin
            want   = op_changed && (now_op >= 8'd1) && (now_op <= 8'd4);
            kind   = KindActivate;
            effect = EffNap0 + now_op[4:0];
         end
         SP_START:   effect = EffStart;
         SP_WELCOME: effect = EffStart + 5'd1;
         SP_DRIVING: effect = EffStart + 5'd2;
         SP_CLIMATE: effect = EffTemp;
         SP_VOICE:   effect = EffVoice;
         SP_DOOR:    effect = EffDoor;
         SP_REAR:    effect = EffRear;
         SP_TWEETER: begin
            kind   = (now_op == 8'd1) ? KindDeactivate : KindActivate;
            effect = EffTweeter;
         end
         SP_VIDEO:   effect = EffVideo;
         default: begin
            want   = 1'b0;
            effect = EffAmbient;
         end
      endcase
   end

   assign push_data.kind    = kind;
   assign push_data.effect  = effect;
   assign push_data.time_ms = req_ff.timestamp;
   assign pop_en            = (state_ff == ST_POP_OUT);

   sccq_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .push_en   ((state_ff == ST_EXAM) && want),
      .push_data (push_data),
      .pop_en    (pop_en),
      .rd_data   (rd_data),
      .empty     (empty)
   );

   assign rsp_strobe                = pop_en;
   assign rsp_payload.found         = !empty;
   assign rsp_payload.command_kind  = empty ? 1'b0 : rd_data.kind;
   assign rsp_payload.effect_id     = empty ? 5'd0 : rd_data.effect;
   assign rsp_payload.command_time  = empty ? 32'd0 : rd_data.time_ms;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= SP_POWER;
         match_id_ff     <= MatchIdReset;
         last_power_ff   <= '0;
         last_theme_ff   <= '0;
         last_nap_ff     <= '0;
         last_mwd_ff     <= '0;
         last_voice_ff   <= '0;
         last_corner_ff  <= '0;
         last_tweeter_ff <= '0;
         last_video_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            match_id_ff <= csr_write_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               step_ff <= SP_POWER;
               if (accept) begin
                  if (req_payload.action == ActPop) begin
                     state_ff <= ST_POP_READ;
                  end else if (req_payload.frame_id == match_id_ff) begin
                     state_ff <= ST_EXAM;
                  end
               end
            end
            ST_EXAM: begin
               if (step_ff == SP_POWER) begin
                  last_power_ff <= req_ff.power_state;
               end
               if (step_ff == SP_POWER && req_ff.power_state == 8'd0) begin
                  state_ff <= ST_IDLE;
               end else if (step_ff == SP_VIDEO) begin
                  last_theme_ff   <= req_ff.theme_code;
                  last_nap_ff     <= req_ff.nap_code;
                  last_mwd_ff     <= req_ff.motion_welcome_drive;
                  last_voice_ff   <= req_ff.voice_code;
                  last_corner_ff  <= req_ff.corner_flags;
                  last_tweeter_ff <= req_ff.tweeter_code;
                  last_video_ff   <= req_ff.video_active;
                  state_ff        <= ST_IDLE;
               end else begin
                  step_ff <= step_type'(step_ff + 4'd1);
               end
            end
            ST_POP_READ: begin
               state_ff <= ST_POP_OUT;
            end
            ST_POP_OUT: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/sccq_checker.sv =====
// ----------------------------------------------------------------------------
// sccq_checker
// Port-level checks for the signal change to command queue.
// ----------------------------------------------------------------------------
module sccq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input sccq_pkg::req_type req_payload,
   input logic              rsp_strobe,
   input sccq_pkg::rsp_type rsp_payload
);
   import sccq_pkg::*;

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_pop_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.action == ActPop) |=> ##1 rsp_strobe)
      else $error("pop request without response");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.found) |->
         (rsp_payload.command_kind == 1'b0 && rsp_payload.effect_id == 5'd0 &&
          rsp_payload.command_time == 32'd0))
      else $error("empty pop with nonzero fields");

   a_effect_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.found) |-> (rsp_payload.effect_id <= EffVideo))
      else $error("effect id out of range");

endmodule

bind signal_change_to_command_queue_top sccq_checker u_sccq_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
